>>> design/ps2mc_pkg.sv
`timescale 1ns / 1ps

package ps2mc_pkg;

   localparam int POSITION_BITS_DEFAULT = 12;
   localparam int SIZE_BITS             = 13;
   localparam int COORD_BITS            = 12;
   localparam int CSR_INDEX_BITS        = 2;

   localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

   // header byte bit positions
   localparam int HDR_LEFT       = 0;
   localparam int HDR_RIGHT      = 1;
   localparam int HDR_MIDDLE     = 2;
   localparam int HDR_ALWAYS_ONE = 3;
   localparam int HDR_X_SIGN     = 4;
   localparam int HDR_Y_SIGN     = 5;
   localparam int HDR_X_OVF      = 6;
   localparam int HDR_Y_OVF      = 7;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_DX     = 2'd1,
      PHASE_DY     = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       from_aux;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cursor_x;
      logic [COORD_BITS-1:0] cursor_y;
      logic                  left_button;
      logic                  right_button;
      logic                  middle_button;
   } rsp_payload_type;

   // core handshake with the pipeline control in the top level
   typedef struct packed {
      logic step;        // stage register item is consumed this cycle
   } core_ctl_type;

   typedef struct packed {
      logic has_result;  // stage register item completes a good packet
   } core_sts_type;

endpackage

>>> design/ps2_mouse_packet_cursor.sv
`timescale 1ns / 1ps
// Flow: an accepted request is held in the stage register, and its result (if
//   the byte completes a good packet) is then loaded into the result register.
// Throughput: one request per cycle; only a stalled, full result register
//   holds back a byte that completes a packet.
// Reset (synchronous, active high): phase back to header, cursor at 0,0,
//   screen size 1024 x 768, stage and result registers empty.
module ps2_mouse_packet_cursor #(
   parameter int POSITION_BITS = ps2mc_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // byte request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  ps2mc_pkg::req_payload_type             req_payload,
   // cursor result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output ps2mc_pkg::rsp_payload_type             rsp_payload,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ps2mc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ps2mc_pkg::SIZE_BITS-1:0]        csr_data
);
   import ps2mc_pkg::*;

   // screen size registers
   logic [SIZE_BITS-1:0] width_ff, width_in;
   logic [SIZE_BITS-1:0] height_ff, height_in;

   // stage register: one byte request waiting for the decode pass
   logic             in_valid_ff, in_valid_in;
   req_payload_type  in_payload_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff;

   core_ctl_type     ctl;
   core_sts_type     sts;
   rsp_payload_type  core_result;
   logic             rsp_free;

   // register writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_data;
            CSR_SCREEN_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   // The result register empties this cycle or is already empty.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Bytes that make no result never wait on the result side.
   assign ctl.step    = in_valid_ff && (!sts.has_result || rsp_free);
   assign req_ready   = !in_valid_ff || ctl.step;
   assign in_valid_in = req_valid || (in_valid_ff && !ctl.step);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.step && sts.has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   ps2mc_core #(.POSITION_BITS(POSITION_BITS)) u_core (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (in_valid_ff),
      .in_payload    (in_payload_ff),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .ctl           (ctl),
      .sts           (sts),
      .result        (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SCREEN_WIDTH_RESET;
         height_ff    <= SCREEN_HEIGHT_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_payload_ff <= req_payload;
      end
      if (ctl.step && sts.has_result) begin
         rsp_payload_ff <= core_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !ctl.step) |=> (in_valid_ff && $stable(in_payload_ff)))
      else $error("stalled byte request lost from stage register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && sts.has_result) |-> rsp_free)
      else $error("result register overwritten while full");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && sts.has_result) |=> rsp_valid_ff)
      else $error("completed packet produced no result");

endmodule

>>> design/ps2mc_clamp.sv
`timescale 1ns / 1ps

module ps2mc_clamp #(
   parameter int POSITION_BITS = ps2mc_pkg::POSITION_BITS_DEFAULT
) (
   input  logic signed [POSITION_BITS+1:0]     value,
   input  logic [ps2mc_pkg::SIZE_BITS-1:0]     size,
   output logic [POSITION_BITS-1:0]            clamped
);
   import ps2mc_pkg::*;

   localparam int CW = ((POSITION_BITS + 2) > (SIZE_BITS + 1)) ?
                       (POSITION_BITS + 2) : (SIZE_BITS + 1);
   localparam logic signed [CW-1:0] POS_MAX = CW'((64'd1 << POSITION_BITS) - 64'd1);

   logic [SIZE_BITS-1:0]   size_last;
   logic signed [CW-1:0]   size_hi;
   logic signed [CW-1:0]   hi;
   logic signed [CW-1:0]   value_ext;

   // zero size behaves like one, upper bound never beyond the position range
   assign size_last = (size == '0) ? '0 : size - SIZE_BITS'(1);
   assign size_hi   = CW'($signed({1'b0, size_last}));
   assign hi        = (size_hi > POS_MAX) ? POS_MAX : size_hi;
   assign value_ext = CW'(value);

   always_comb begin
      priority if (value_ext < 0) begin
         clamped = '0;
      end else if (value_ext > hi) begin
         clamped = POSITION_BITS'(hi);
      end else begin
         clamped = POSITION_BITS'(value_ext);
      end
   end

endmodule

>>> design/ps2mc_core.sv
`timescale 1ns / 1ps

module ps2mc_core #(
   parameter int POSITION_BITS = ps2mc_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  ps2mc_pkg::req_payload_type       in_payload,
   input  logic [ps2mc_pkg::SIZE_BITS-1:0]  screen_width,
   input  logic [ps2mc_pkg::SIZE_BITS-1:0]  screen_height,
   input  ps2mc_pkg::core_ctl_type          ctl,
   output ps2mc_pkg::core_sts_type          sts,
   output ps2mc_pkg::rsp_payload_type       result
);
   import ps2mc_pkg::*;

   localparam int SW = POSITION_BITS + 2;

   phase_type                  phase_ff, phase_in;
   logic [7:0]                 header_ff, header_in;
   logic [7:0]                 dx_byte_ff, dx_byte_in;
   logic [POSITION_BITS-1:0]   pos_x_ff, pos_x_in;
   logic [POSITION_BITS-1:0]   pos_y_ff, pos_y_in;

   logic                       take;
   logic                       overflow;
   logic signed [8:0]          delta_x;
   logic signed [8:0]          delta_y;
   logic signed [SW-1:0]       sum_x;
   logic signed [SW-1:0]       sum_y;
   logic [POSITION_BITS-1:0]   new_x;
   logic [POSITION_BITS-1:0]   new_y;

   assign take     = in_valid && in_payload.from_aux;
   assign overflow = header_ff[HDR_X_OVF] || header_ff[HDR_Y_OVF];
   assign delta_x  = $signed({header_ff[HDR_X_SIGN], dx_byte_ff});
   assign delta_y  = $signed({header_ff[HDR_Y_SIGN], in_payload.data_byte});
   // row grows downward, so Y movement is subtracted
   assign sum_x    = $signed({2'b00, pos_x_ff}) + SW'(delta_x);
   assign sum_y    = $signed({2'b00, pos_y_ff}) - SW'(delta_y);

   ps2mc_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_x (
      .value   (sum_x),
      .size    (screen_width),
      .clamped (new_x)
   );

   ps2mc_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_y (
      .value   (sum_y),
      .size    (screen_height),
      .clamped (new_y)
   );

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (ctl.step && take) begin
         unique case (phase_ff)
            PHASE_DX: phase_in = PHASE_DY;
            PHASE_DY: phase_in = PHASE_HEADER;
            default:  phase_in = in_payload.data_byte[HDR_ALWAYS_ONE] ? PHASE_DX
                                                                      : PHASE_HEADER;
         endcase
      end
   end

   // outputs and datapath updates per phase
   always_comb begin
      header_in      = header_ff;
      dx_byte_in     = dx_byte_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      sts.has_result = 1'b0;
      unique case (phase_ff)
         PHASE_DX: begin
            if (ctl.step && take) dx_byte_in = in_payload.data_byte;
         end
         PHASE_DY: begin
            sts.has_result = take && !overflow;
            if (ctl.step && take && !overflow) begin
               pos_x_in = new_x;
               pos_y_in = new_y;
            end
         end
         default: begin
            if (ctl.step && take) header_in = in_payload.data_byte;
         end
      endcase
   end

   assign result.cursor_x      = COORD_BITS'(new_x);
   assign result.cursor_y      = COORD_BITS'(new_y);
   assign result.left_button   = header_ff[HDR_LEFT];
   assign result.right_button  = header_ff[HDR_RIGHT];
   assign result.middle_button = header_ff[HDR_MIDDLE];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_HEADER;
         header_ff  <= '0;
         dx_byte_ff <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         header_ff  <= header_in;
         dx_byte_ff <= dx_byte_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
      end
   end

   a_result_only_on_dy: assert property (@(posedge clock) disable iff (reset)
      sts.has_result |-> (phase_ff == PHASE_DY))
      else $error("result flagged outside Y byte phase");

   a_bad_header_resync: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && take && phase_ff == PHASE_HEADER &&
       !in_payload.data_byte[HDR_ALWAYS_ONE]) |=> (phase_ff == PHASE_HEADER))
      else $error("header without sync bit did not hold phase");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !(ctl.step && sts.has_result) |=> ($stable(pos_x_ff) && $stable(pos_y_ff)))
      else $error("position moved without a completed packet");

   a_no_byte_lost: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && !take) |=> $stable(phase_ff))
      else $error("non-aux byte changed packet phase");

endmodule

>>> bench/ps2mc_checker.sv
`timescale 1ns / 1ps

module ps2mc_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  ps2mc_pkg::req_payload_type           req_payload,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  ps2mc_pkg::rsp_payload_type           rsp_payload,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [ps2mc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mc_pkg::SIZE_BITS-1:0]      csr_data,
   output int                                   error_count,
   output int                                   pending_count
);
   import ps2mc_pkg::*;

   localparam int POS_MAX           = (1 << POSITION_BITS_DEFAULT) - 1;
   localparam int DELTA_SIGN_WEIGHT = 256;

   phase_type             phase;
   logic [7:0]            header;
   logic [7:0]            dx_byte;
   int                    pos_x;
   int                    pos_y;
   logic [SIZE_BITS-1:0]  width_q;
   logic [SIZE_BITS-1:0]  height_q;
   rsp_payload_type       cursor_q[$];
   rsp_payload_type       want;

   // zero size behaves as one; the upper bound never exceeds the position range
   function automatic int clamp_to_screen(input int v, input logic [SIZE_BITS-1:0] size);
      int hi_lim;
      hi_lim = (size == 0) ? 0 : int'(size) - 1;
      if (hi_lim > POS_MAX) hi_lim = POS_MAX;
      if (v > hi_lim) return hi_lim;
      if (v < 0) return 0;
      return v;
   endfunction

   function void take_mouse_byte(input req_payload_type req);
      rsp_payload_type upd;
      int              dx;
      int              dy;
      if (!req.from_aux) return;
      case (phase)
         PHASE_DX: begin
            dx_byte = req.data_byte;
            phase   = PHASE_DY;
         end
         PHASE_DY: begin
            phase = PHASE_HEADER;
            if (!header[HDR_X_OVF] && !header[HDR_Y_OVF]) begin
               dx = int'(dx_byte) - (header[HDR_X_SIGN] ? DELTA_SIGN_WEIGHT : 0);
               dy = int'(req.data_byte) - (header[HDR_Y_SIGN] ? DELTA_SIGN_WEIGHT : 0);
               pos_x = clamp_to_screen(pos_x + dx, width_q);
               pos_y = clamp_to_screen(pos_y - dy, height_q);
               upd.cursor_x      = pos_x[COORD_BITS-1:0];
               upd.cursor_y      = pos_y[COORD_BITS-1:0];
               upd.left_button   = header[HDR_LEFT];
               upd.right_button  = header[HDR_RIGHT];
               upd.middle_button = header[HDR_MIDDLE];
               cursor_q.push_back(upd);
            end
         end
         default: begin
            header = req.data_byte;
            phase  = header[HDR_ALWAYS_ONE] ? PHASE_DX : PHASE_HEADER;
         end
      endcase
   endfunction

   function void check_field(input string name, input logic [COORD_BITS-1:0] want_v,
                             input logic [COORD_BITS-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase         = PHASE_HEADER;
         header        = '0;
         dx_byte       = '0;
         pos_x         = 0;
         pos_y         = 0;
         width_q       = SCREEN_WIDTH_RESET;
         height_q      = SCREEN_HEIGHT_RESET;
         error_count   = 0;
         cursor_q.delete();
      end else begin
         // a request's result comes out of the result register behind the stage register: compare first
         if (rsp_valid && rsp_ready) begin
            if (cursor_q.size() == 0) begin
               $error("cursor update with none expected");
               error_count++;
            end else begin
               want = cursor_q.pop_front();
               check_field("cursor_x", want.cursor_x, rsp_payload.cursor_x);
               check_field("cursor_y", want.cursor_y, rsp_payload.cursor_y);
               check_field("left_button", COORD_BITS'(want.left_button),
                           COORD_BITS'(rsp_payload.left_button));
               check_field("right_button", COORD_BITS'(want.right_button),
                           COORD_BITS'(rsp_payload.right_button));
               check_field("middle_button", COORD_BITS'(want.middle_button),
                           COORD_BITS'(rsp_payload.middle_button));
            end
         end
         if (req_valid && req_ready) take_mouse_byte(req_payload);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  width_q  = csr_data;
               CSR_SCREEN_HEIGHT: height_q = csr_data;
               default: ;
            endcase
         end
      end
      pending_count = cursor_q.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ps2mc_pkg::*;

   localparam int GAP_MAX       = 14;
   localparam int HOLD_CYCLES   = 120;    // one long receiver stall to back up the block
   localparam int SETTLE_CYCLES = 4;      // stage + result register, with margin
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PUSH_PACKETS  = 30;     // packets per drift run, enough to cross 4096
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_SPARE = 2'd3;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_valid   = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [SIZE_BITS-1:0]      csr_data    = '0;

   int   error_count;
   int   pending_count;
   int   aux_sent    = 0;
   int   cycle_count = 0;
   logic quiet       = 1'b0;   // no idling on either side while set, apart from one long receiver stall
   logic rsp_held    = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ps2_mouse_packet_cursor i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   ps2mc_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // One request: idle for a random gap (valid low), then offer until taken.
   // Returns on the falling edge after acceptance with valid still high, so a
   // zero gap on the next request keeps valid up without a low pulse.
   task automatic send_byte(input logic [7:0] data, input logic aux);
      int              gap;
      req_payload_type item;
      gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
      item.data_byte = data;
      item.from_aux  = aux;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
      if (aux) aux_sent++;
   endtask

   // keyboard-side byte slipped into the stream now and then
   task automatic maybe_kbd_byte();
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 11) == 0) send_byte(junk, 1'b0);
   endtask

   // Well-formed packet with random content. push > 0 drifts toward the
   // bottom-right corner, push < 0 toward the top-left; the drift is what
   // gets the cursor onto the far clamps of a 4096-wide screen.
   task automatic send_packet(input int push);
      logic [7:0] hdr;
      logic [7:0] dx;
      logic [7:0] dy;
      hdr = 8'($urandom_range(0, 255));
      dx  = 8'($urandom_range(0, 255));
      dy  = 8'($urandom_range(0, 255));
      hdr[HDR_ALWAYS_ONE] = 1'b1;
      // overflow packets are kept rare, most packets must move the cursor
      if ($urandom_range(0, 7) != 0) begin
         hdr[HDR_X_OVF] = 1'b0;
         hdr[HDR_Y_OVF] = 1'b0;
      end
      if (push != 0 && $urandom_range(0, 7) != 0) begin
         // screen y grows downward, so a negative dy moves the cursor down
         hdr[HDR_X_SIGN] = (push < 0);
         hdr[HDR_Y_SIGN] = (push > 0);
         dx = 8'((push < 0) ? $urandom_range(0, 127) : $urandom_range(128, 255));
         dy = 8'((push > 0) ? $urandom_range(0, 127) : $urandom_range(128, 255));
      end
      send_byte(hdr, 1'b1);
      maybe_kbd_byte();
      send_byte(dx, 1'b1);
      maybe_kbd_byte();
      send_byte(dy, 1'b1);
   endtask

   // Truncated packet: header and maybe dx, then the next bytes fall into
   // the wrong slots. Three bytes without the always-one bit guarantee the
   // decoder is back on a header afterwards.
   task automatic send_broken_packet();
      logic [7:0] b;
      int         n;
      int         i;
      n = $urandom_range(1, 2);
      for (i = 0; i < n; i++) begin
         b = 8'($urandom_range(0, 255));
         if (i == 0) b[HDR_ALWAYS_ONE] = 1'b1;
         send_byte(b, 1'b1);
      end
      repeat (3) begin
         b = 8'($urandom_range(0, 255));
         b[HDR_ALWAYS_ONE] = 1'b0;
         send_byte(b, 1'b1);
      end
   endtask

   task automatic run_random(input int n_aux);
      int         start;
      int         k;
      int         sel;
      int         push;
      logic [7:0] b;
      start = aux_sent;
      k     = 0;
      while (aux_sent - start < n_aux) begin
         push = (k < PUSH_PACKETS) ? 1 : (k < 2 * PUSH_PACKETS) ? -1 : 0;
         sel  = $urandom_range(0, 19);
         if (sel == 0) begin
            // stray header without the always-one bit: dropped
            b = 8'($urandom_range(0, 255));
            b[HDR_ALWAYS_ONE] = 1'b0;
            send_byte(b, 1'b1);
         end else if (sel == 1) begin
            send_broken_packet();
         end else begin
            send_packet(push);
         end
         k++;
      end
   endtask

   // Block is idle once every expected update is back and the stage register
   // has had time to drop a byte that makes no result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [SIZE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_setup(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h,
                            input logic calm, input logic spare, input int n_aux);
      logic [SIZE_BITS-1:0] junk;
      junk = SIZE_BITS'($urandom_range(0, 8191));
      wait_idle();
      // write to an unmapped index: must not touch either screen size
      if (spare) write_csr(CSR_INDEX_SPARE, junk);
      write_csr(CSR_SCREEN_WIDTH, w);
      write_csr(CSR_SCREEN_HEIGHT, h);
      csr_valid <= 1'b0;
      quiet = calm;
      run_random(n_aux);
   endtask

   // Receiver: random stall before each update, none in quiet stretches.
   // The first quiet stretch opens with one long stall while the sender keeps
   // streaming, so the result and stage registers fill and req_ready drops.
   initial begin : rsp_side
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
         if (quiet && !rsp_held) begin
            gap      = HOLD_CYCLES;
            rsp_held = 1'b1;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, on the reset screen size of 1024 x 768 from 0,0
      send_byte(8'hFF, 1'b0);   // not from the mouse port: ignored
      send_byte(8'h00, 1'b1);   // header without always-one bit: dropped
      send_byte(8'hF7, 1'b1);   // same, with every other bit set
      // all buttons, x +127, y +128 upward clamps row at 0; keyboard byte mid-packet
      send_byte(8'h0F, 1'b1);
      send_byte(8'h7F, 1'b1);
      send_byte(8'h55, 1'b0);
      send_byte(8'h80, 1'b1);
      // both signs with zero bytes: most negative deltas, x clamps at 0
      send_byte(8'h38, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b1);
      // x overflow, y overflow, both: packets discarded, phase back to header
      send_byte(8'h48, 1'b1);
      send_byte(8'h7F, 1'b1);
      send_byte(8'h7F, 1'b1);
      send_byte(8'h88, 1'b1);
      send_byte(8'h7F, 1'b1);
      send_byte(8'h7F, 1'b1);
      send_byte(8'hF8, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b1);
      // dx of -1, dy of +255 moves up
      send_byte(8'h19, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b1);
      // dx of +1, dy of -255 moves down
      send_byte(8'h2A, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h01, 1'b1);

      // random part over several screen sizes: oversize widths hit the
      // position-range clamp, zero sizes pin the axis at 0
      run_setup(13'd8191, 13'd4096, 1'b0, 1'b0, 200);
      run_setup(13'd1,    13'd0,    1'b1, 1'b0, 40);
      run_setup(13'd0,    13'd8191, 1'b0, 1'b1, 40);
      run_setup(13'd4096, 13'd1,    1'b1, 1'b0, 50);
      run_setup(13'd640,  13'd480,  1'b0, 1'b0, 40);
      run_setup(13'd300,  13'd200,  1'b0, 1'b0, 40);

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
